// ----- design/bfd_pkg.sv -----
package bfd_pkg;

  // Event codes reported for every received word
  typedef enum logic [2:0] {
    EV_IDLE    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_REJECT  = 3'd4
  } event_e;

  // Configuration register indexes
  localparam logic [1:0] CfgSyncFirst   = 2'd0;
  localparam logic [1:0] CfgSyncSecond  = 2'd1;
  localparam logic [1:0] CfgWantedClass = 2'd2;
  localparam logic [1:0] CfgMaxPayload  = 2'd3;

  // Sync, class, id, two length bytes and two checksum bytes
  localparam logic [8:0] FrameOverhead = 9'd8;

  // Fixed byte positions within a frame
  localparam logic [8:0] PosHunt     = 9'd0;
  localparam logic [8:0] PosSync2    = 9'd1;
  localparam logic [8:0] PosClass    = 9'd2;
  localparam logic [8:0] PosId       = 9'd3;
  localparam logic [8:0] PosLenLow   = 9'd4;
  localparam logic [8:0] PosLenHigh  = 9'd5;
  localparam logic [8:0] PosPayload0 = 9'd6;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] wanted_class;
    logic [7:0] max_payload;
  } cfg_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] msg_class;
    logic [7:0] msg_id;
    logic [7:0] payload_length;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
  } res_t;

endpackage

// ----- design/bfd_step.sv -----
module bfd_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [7:0]        byte_i,
  input  bfd_pkg::cfg_t     cfg_i,
  output bfd_pkg::res_t     res_o
);

  logic [8:0] position_q, position_d;
  logic [8:0] frame_total_q, frame_total_d;
  logic [7:0] fletcher_a_q, fletcher_a_d;
  logic [7:0] fletcher_b_q, fletcher_b_d;
  logic [7:0] held_class_q, held_class_d;
  logic [7:0] held_id_q, held_id_d;

  // Frame state advances only when a word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= bfd_pkg::PosHunt;
      frame_total_q <= '0;
      fletcher_a_q  <= '0;
      fletcher_b_q  <= '0;
      held_class_q  <= '0;
      held_id_q     <= '0;
    end else if (advance_i) begin
      position_q    <= position_d;
      frame_total_q <= frame_total_d;
      fletcher_a_q  <= fletcher_a_d;
      fletcher_b_q  <= fletcher_b_d;
      held_class_q  <= held_class_d;
      held_id_q     <= held_id_d;
    end
  end

  // Per-byte parse step: one compare and the two Fletcher adds
  always_comb begin
    logic [7:0] acc_a;
    logic [7:0] acc_b;
    logic [9:0] pos_p2;
    logic [9:0] total_ext;

    acc_a     = fletcher_a_q + byte_i;
    acc_b     = fletcher_b_q + acc_a;
    pos_p2    = {1'b0, position_q} + 10'd2;
    total_ext = {1'b0, frame_total_q};

    position_d    = position_q;
    frame_total_d = frame_total_q;
    fletcher_a_d  = fletcher_a_q;
    fletcher_b_d  = fletcher_b_q;
    held_class_d  = held_class_q;
    held_id_d     = held_id_q;
    res_o         = '0;
    res_o.ev      = bfd_pkg::EV_IDLE;

    if (position_q == bfd_pkg::PosHunt) begin
      if (byte_i == cfg_i.sync_first) begin
        position_d = bfd_pkg::PosSync2;
        res_o.ev   = bfd_pkg::EV_HEADER;
      end
    end else if (position_q == bfd_pkg::PosSync2) begin
      // A wrong second sync byte is not retried as a first sync byte
      if (byte_i == cfg_i.sync_second) begin
        position_d = bfd_pkg::PosClass;
        res_o.ev   = bfd_pkg::EV_HEADER;
      end else begin
        position_d = bfd_pkg::PosHunt;
      end
    end else if (position_q == bfd_pkg::PosClass) begin
      // Checksums restart at the class byte
      if (byte_i == cfg_i.wanted_class) begin
        held_class_d = byte_i;
        fletcher_a_d = byte_i;
        fletcher_b_d = byte_i;
        position_d   = bfd_pkg::PosId;
        res_o.ev     = bfd_pkg::EV_HEADER;
      end else begin
        fletcher_a_d = '0;
        fletcher_b_d = '0;
        position_d   = bfd_pkg::PosHunt;
        res_o.ev     = bfd_pkg::EV_REJECT;
      end
    end else if (position_q == bfd_pkg::PosId) begin
      held_id_d    = byte_i;
      fletcher_a_d = acc_a;
      fletcher_b_d = acc_b;
      position_d   = bfd_pkg::PosLenLow;
      res_o.ev     = bfd_pkg::EV_HEADER;
    end else if (position_q == bfd_pkg::PosLenLow) begin
      // Oversized frames are dropped before any payload is counted
      if (byte_i > cfg_i.max_payload) begin
        position_d = bfd_pkg::PosHunt;
        res_o.ev   = bfd_pkg::EV_REJECT;
      end else begin
        frame_total_d = {1'b0, byte_i} + bfd_pkg::FrameOverhead;
        fletcher_a_d  = acc_a;
        fletcher_b_d  = acc_b;
        position_d    = bfd_pkg::PosLenHigh;
        res_o.ev      = bfd_pkg::EV_HEADER;
      end
    end else if (pos_p2 < total_ext) begin
      // High length byte or payload byte: both enter the checksums
      fletcher_a_d = acc_a;
      fletcher_b_d = acc_b;
      if (position_q == bfd_pkg::PosLenHigh) begin
        res_o.ev = bfd_pkg::EV_HEADER;
      end else begin
        res_o.ev            = bfd_pkg::EV_PAYLOAD;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = position_q[7:0] - bfd_pkg::PosPayload0[7:0];
      end
      position_d = position_q + 9'd1;
    end else if (pos_p2 == total_ext) begin
      // First checksum byte
      if (byte_i == fletcher_a_q) begin
        position_d = position_q + 9'd1;
        res_o.ev   = bfd_pkg::EV_HEADER;
      end else begin
        position_d = bfd_pkg::PosHunt;
        res_o.ev   = bfd_pkg::EV_REJECT;
      end
    end else begin
      // Second checksum byte closes the frame either way
      if (byte_i == fletcher_b_q) begin
        res_o.ev             = bfd_pkg::EV_GOOD;
        res_o.msg_class      = held_class_q;
        res_o.msg_id         = held_id_q;
        res_o.payload_length = frame_total_q[7:0] - bfd_pkg::FrameOverhead[7:0];
      end else begin
        res_o.ev = bfd_pkg::EV_REJECT;
      end
      position_d = bfd_pkg::PosHunt;
    end

    res_o.sum_a = fletcher_a_d;
    res_o.sum_b = fletcher_b_d;
  end

`ifndef ASSERT_OFF
  // Inside a frame body the position never runs past the captured frame size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (position_q < bfd_pkg::PosLenHigh) || (position_q < frame_total_q))
    else $error("frame position beyond frame size");

  // Once past the length byte the captured frame size covers the overhead
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (position_q < bfd_pkg::PosLenHigh) || (frame_total_q >= bfd_pkg::FrameOverhead))
    else $error("frame size below overhead inside a frame");

  // A payload word moves the position on by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && (res_o.ev == bfd_pkg::EV_PAYLOAD))
      |=> (position_q == $past(position_q) + 9'd1))
    else $error("payload word did not advance position");
`endif

endmodule

// ----- design/binary_frame_deframer_fletcher.sv -----
// Channel  | Direction | Handshake                  | Payload
// rx       | in        | in_valid_i / in_ready_o    | rx_byte_i
// result   | out       | out_valid_o / out_ready_i  | event_res_o .. sum_b_o
// config   | in        | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while the result is not stalled; an accepted byte is
// held in the input register, then goes through the parse step into the result register.
// The combinational parse step (one compare, two 8-bit adds) sets the rate.
// Reset clears the frame state to hunting and loads the default register values.
// A stalled result holds; the input register still takes one more word behind it.
module binary_frame_deframer_fletcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] msg_class_o,
  output logic [7:0] msg_id_o,
  output logic [7:0] payload_length_o,
  output logic [7:0] sum_a_o,
  output logic [7:0] sum_b_o
);

  bfd_pkg::cfg_t cfg_q;
  logic          in_vld_q;
  logic [7:0]    in_byte_q;
  logic          out_vld_q;
  bfd_pkg::res_t res_q;
  bfd_pkg::res_t res_d;
  logic          advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first   <= 8'd181;
      cfg_q.sync_second  <= 8'd98;
      cfg_q.wanted_class <= 8'd1;
      cfg_q.max_payload  <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfd_pkg::CfgSyncFirst:   cfg_q.sync_first   <= cfg_data_i;
        bfd_pkg::CfgSyncSecond:  cfg_q.sync_second  <= cfg_data_i;
        bfd_pkg::CfgWantedClass: cfg_q.wanted_class <= cfg_data_i;
        bfd_pkg::CfgMaxPayload:  cfg_q.max_payload  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A word moves into the result register when the result slot is free
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  bfd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign event_res_o      = res_q.ev;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_index_o  = res_q.payload_index;
  assign msg_class_o      = res_q.msg_class;
  assign msg_id_o         = res_q.msg_id;
  assign payload_length_o = res_q.payload_length;
  assign sum_a_o          = res_q.sum_a;
  assign sum_b_o          = res_q.sum_b;

`ifndef ASSERT_OFF
  // Only the five defined events are ever reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o <= 3'(bfd_pkg::EV_REJECT)))
    else $error("undefined event code");

  // Frame fields are zero except on a good frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o != 3'(bfd_pkg::EV_GOOD)))
      |-> ((msg_class_o == 8'd0) && (msg_id_o == 8'd0) && (payload_length_o == 8'd0)))
    else $error("frame fields set outside a good frame");

  // Payload fields are zero except on a payload word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o != 3'(bfd_pkg::EV_PAYLOAD)))
      |-> ((payload_byte_o == 8'd0) && (payload_index_o == 8'd0)))
    else $error("payload fields set outside a payload word");
`endif

endmodule
